@@ hw/rtl/kst_pkg.sv @@
// shared types and constants for the key session tracker
package kst_pkg;

    localparam int unsigned SESSIONS      = 10;
    localparam int unsigned SESS_W        = $clog2(SESSIONS);
    localparam int unsigned MAX_RESULTS   = 20;

    typedef enum logic [2:0] {
        REQ_PRESS   = 3'd0,
        REQ_RELEASE = 3'd1,
        REQ_POS     = 3'd2,
        REQ_LAYER   = 3'd3,
        REQ_TICK    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ACT_START_PRESS   = 3'd0,
        ACT_START_RELEASE = 3'd1,
        ACT_CONT_PRESS    = 3'd2,
        ACT_CONT_RELEASE  = 3'd3,
        ACT_END_PRESS     = 3'd4,
        ACT_END_RELEASE   = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        CFG_IGN_KEYS   = 2'd0,
        CFG_IGN_LAYERS = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_TAP_HOLD   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRESS,
        ST_EMIT_SP,
        ST_EMIT_SR,
        ST_EMIT_CP,
        ST_EMIT_CR,
        ST_END_CR,
        ST_END_EP,
        ST_END_ER
    } state_t;

    // one word queued toward the output register
    typedef struct packed {
        act_t        action;
        logic [5:0]  position;
        logic [15:0] hold;
        logic        last;
    } word_t;

endpackage

@@ hw/rtl/kst_out_reg.sv @@
// output register holding one result word
module kst_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  kst_pkg::word_t push_word,
    output logic          full,
    input  logic          m_ready,
    output logic          m_valid,
    output kst_pkg::word_t m_word
);
    logic           valid_reg;
    kst_pkg::word_t word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            word_reg <= push_word;
        end
    end

    assign full    = valid_reg && !m_ready;
    assign m_valid = valid_reg;
    assign m_word  = word_reg;
endmodule

@@ hw/rtl/key_session_interrupt_tracker.sv @@
// top level: session table, scanning sequencer and output register
// One item is handled by a sequencer that walks the ten-entry session table
// one entry per cycle through a single shared compare and decrement unit,
// and emits its result words, one per cycle while the output register is not
// full, into an output register; a tick resumes its scan after each ended
// session. A release of a tracked key passes through idle, a scan of all ten
// entries, an update step and one word. s_ready is low while an item is in
// work. Result words are ordered exactly as produced; last_action marks the
// final word of each item. Configuration writes are always accepted and are
// meant to be made only while no item is in work.
module key_session_interrupt_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_key_position,
    input  logic        s_key_down,
    input  logic [4:0]  s_layer_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [5:0]  m_action_position,
    output logic [15:0] m_hold_ticks,
    output logic        m_last_action,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int unsigned N  = kst_pkg::SESSIONS;
    localparam int unsigned SW = kst_pkg::SESS_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(N - 1);

    logic [63:0] ign_keys_reg;
    logic [31:0] ign_layers_reg;
    logic [15:0] timeout_reg;
    logic [15:0] tap_hold_reg;

    logic [N-1:0] active_reg, held_reg, first_reg, run_reg;
    logic [5:0]   key_reg  [N];
    logic [15:0]  left_reg [N];

    kst_pkg::state_t state_reg, state_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic [SW-1:0]   sel_reg, sel_next;
    logic            found_reg, found_next;
    logic            free_found_reg, free_found_next;
    logic [SW-1:0]   free_reg, free_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [15:0]     ehold_reg, ehold_next;
    logic            cont_reg, cont_next;   // resume scan after an ending (tick)
    kst_pkg::req_t   req_reg;
    logic [5:0]      pos_reg;
    logic            down_reg;
    logic [4:0]      layer_reg;

    logic           push, out_full;
    kst_pkg::word_t push_word, m_word;

    kst_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_word(push_word),
        .full(out_full), .m_ready(m_ready), .m_valid(m_valid), .m_word(m_word)
    );

    assign m_action          = m_word.action;
    assign m_action_position = m_word.position;
    assign m_hold_ticks      = m_word.hold;
    assign m_last_action     = m_word.last;
    assign cfg_ready         = 1'b1;
    assign s_ready           = (state_reg == kst_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ign_keys_reg   <= '0;
            ign_layers_reg <= '0;
            timeout_reg    <= '0;
            tap_hold_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (kst_pkg::cfg_idx_t'(cfg_index))
                kst_pkg::CFG_IGN_KEYS:   ign_keys_reg   <= cfg_data;
                kst_pkg::CFG_IGN_LAYERS: ign_layers_reg <= cfg_data[31:0];
                kst_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_data[15:0];
                kst_pkg::CFG_TAP_HOLD:   tap_hold_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared unit: one table entry seen per cycle
    logic        e_act, e_held, e_run;
    logic [5:0]  e_key;
    logic [15:0] e_left, e_dec;
    logic        key_match, ign_key, ign_layer;
    assign e_act     = active_reg[idx_reg];
    assign e_held    = held_reg[idx_reg];
    assign e_run     = run_reg[idx_reg];
    assign e_key     = key_reg[idx_reg];
    assign e_left    = left_reg[idx_reg];
    assign e_dec     = (e_left != 16'd0) ? e_left - 16'd1 : 16'd0;
    assign key_match = (e_key == pos_reg);
    assign ign_key   = ign_keys_reg[pos_reg];
    assign ign_layer = ign_layers_reg[layer_reg];

    // table write requests from the sequencer
    logic        w_en;
    logic [SW-1:0] w_idx;
    logic        w_act, w_held, w_first, w_run;
    logic [5:0]  w_key;
    logic [15:0] w_left;
    logic        last_idx, more_words;
    logic        tail_ends, tail_any;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sel_next        = sel_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        cnt_next        = cnt_reg;
        ehold_next      = ehold_reg;
        cont_next       = cont_reg;
        push            = 1'b0;
        push_word       = '{kst_pkg::ACT_CONT_PRESS, pos_reg, 16'd0, 1'b0};
        w_en    = 1'b0;
        w_idx   = idx_reg;
        w_act   = e_act;
        w_held  = e_held;
        w_first = first_reg[idx_reg];
        w_run   = e_run;
        w_key   = e_key;
        w_left  = e_left;
        last_idx   = (idx_reg == LAST_IDX);
        more_words = 1'b0;

        unique case (state_reg)
            kst_pkg::ST_IDLE: begin
                idx_next = '0; found_next = 1'b0; free_found_next = 1'b0;
                cnt_next = '0; cont_next = 1'b0;
                if (s_valid) begin
                    state_next = kst_pkg::ST_SCAN;
                end
            end
            kst_pkg::ST_SCAN: begin
                state_next = kst_pkg::ST_SCAN;
                if (!last_idx) begin
                    idx_next = idx_reg + SW'(1);
                end
                priority case (req_reg)
                    kst_pkg::REQ_PRESS, kst_pkg::REQ_RELEASE: begin
                        if (!found_reg && e_act && key_match) begin
                            found_next = 1'b1; sel_next = idx_reg;
                        end
                        if (!free_found_reg && !e_act) begin
                            free_found_next = 1'b1; free_next = idx_reg;
                        end
                        if (last_idx) begin
                            state_next = kst_pkg::ST_PRESS;
                        end
                    end
                    kst_pkg::REQ_POS: begin
                        if (e_act && !key_match) begin
                            if (!ign_key) begin
                                sel_next = idx_reg; ehold_next = tap_hold_reg;
                                state_next = e_held ? kst_pkg::ST_END_CR
                                                    : kst_pkg::ST_END_EP;
                            end else begin
                                w_en = 1'b1;
                                if (down_reg) w_run = 1'b0;
                                else if (timeout_reg != 16'd0) begin
                                    w_run = 1'b1; w_left = timeout_reg;
                                end
                            end
                        end
                        if (last_idx && state_next == kst_pkg::ST_SCAN) begin
                            state_next = kst_pkg::ST_IDLE;
                        end
                    end
                    kst_pkg::REQ_LAYER: begin
                        if (down_reg && !ign_layer && e_act) begin
                            sel_next = idx_reg; ehold_next = 16'd0;
                            state_next = e_held ? kst_pkg::ST_END_CR
                                                : kst_pkg::ST_END_EP;
                        end else if (!down_reg || ign_layer || last_idx) begin
                            state_next = kst_pkg::ST_IDLE;
                        end
                    end
                    kst_pkg::REQ_TICK: begin
                        if (e_run) begin
                            w_en = 1'b1; w_left = e_dec;
                            if (e_dec == 16'd0) begin
                                if (e_act && !e_held) begin
                                    if (cnt_reg + 5'd2 <= 5'(kst_pkg::MAX_RESULTS)) begin
                                        sel_next = idx_reg;
                                        ehold_next = tap_hold_reg;
                                        cont_next = !last_idx;
                                        state_next = kst_pkg::ST_END_EP;
                                    end
                                end else begin
                                    w_run = 1'b0;
                                end
                            end
                        end
                        if (last_idx && state_next == kst_pkg::ST_SCAN) begin
                            state_next = kst_pkg::ST_IDLE;
                        end
                    end
                    default: state_next = kst_pkg::ST_IDLE;
                endcase
                // close an item whose scan ended with words already sent
                if (state_next == kst_pkg::ST_IDLE && cnt_reg != 5'd0) begin
                    state_next = kst_pkg::ST_IDLE;
                end
            end
            kst_pkg::ST_PRESS: begin
                state_next = kst_pkg::ST_IDLE;
                if (req_reg == kst_pkg::REQ_RELEASE) begin
                    if (found_reg) begin
                        w_en = 1'b1; w_idx = sel_reg;
                        w_act = 1'b1; w_held = 1'b0; w_key = key_reg[sel_reg];
                        w_first = first_reg[sel_reg];
                        w_run = run_reg[sel_reg]; w_left = left_reg[sel_reg];
                        if (timeout_reg != 16'd0) begin
                            w_run = 1'b1; w_left = timeout_reg;
                        end
                        state_next = kst_pkg::ST_EMIT_CR;
                    end
                end else if (found_reg || free_found_reg) begin
                    w_en = 1'b1; w_idx = found_reg ? sel_reg : free_reg;
                    w_act = 1'b1; w_held = 1'b1; w_key = pos_reg; w_first = 1'b0;
                    sel_next = w_idx;
                    if (found_reg) begin
                        w_run = run_reg[sel_reg]; w_left = left_reg[sel_reg];
                        state_next = first_reg[sel_reg] ? kst_pkg::ST_EMIT_SP
                                                        : kst_pkg::ST_EMIT_CP;
                    end else begin
                        w_run = 1'b0; w_left = 16'd0;
                        state_next = kst_pkg::ST_EMIT_SP;
                    end
                end
            end
            kst_pkg::ST_EMIT_SP, kst_pkg::ST_EMIT_SR, kst_pkg::ST_EMIT_CP,
            kst_pkg::ST_EMIT_CR: begin
                if (!out_full) begin
                    push = 1'b1;
                    unique case (state_reg)
                        kst_pkg::ST_EMIT_SP: begin
                            push_word.action = kst_pkg::ACT_START_PRESS;
                            state_next = kst_pkg::ST_EMIT_SR;
                        end
                        kst_pkg::ST_EMIT_SR: begin
                            push_word.action = kst_pkg::ACT_START_RELEASE;
                            state_next = kst_pkg::ST_EMIT_CP;
                        end
                        kst_pkg::ST_EMIT_CP: begin
                            push_word.action = kst_pkg::ACT_CONT_PRESS;
                            push_word.last = 1'b1;
                            state_next = kst_pkg::ST_IDLE;
                        end
                        default: begin
                            push_word.action = kst_pkg::ACT_CONT_RELEASE;
                            push_word.last = 1'b1;
                            state_next = kst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            kst_pkg::ST_END_CR, kst_pkg::ST_END_EP, kst_pkg::ST_END_ER: begin
                push_word.position = key_reg[sel_reg];
                if (!out_full) begin
                    push = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                    unique case (state_reg)
                        kst_pkg::ST_END_CR: begin
                            push_word.action = kst_pkg::ACT_CONT_RELEASE;
                            state_next = kst_pkg::ST_END_EP;
                        end
                        kst_pkg::ST_END_EP: begin
                            push_word.action = kst_pkg::ACT_END_PRESS;
                            push_word.hold = ehold_reg;
                            w_en = 1'b1; w_idx = sel_reg;
                            w_act = 1'b0; w_run = 1'b0; w_held = held_reg[sel_reg];
                            w_first = first_reg[sel_reg]; w_key = key_reg[sel_reg];
                            w_left = left_reg[sel_reg];
                            state_next = kst_pkg::ST_END_ER;
                        end
                        default: begin
                            push_word.action = kst_pkg::ACT_END_RELEASE;
                            // tick: does any later entry still end a session
                            more_words = cont_reg && tail_ends;
                            push_word.last = !more_words;
                            state_next = cont_reg ? kst_pkg::ST_SCAN : kst_pkg::ST_IDLE;
                            if (cont_reg) idx_next = sel_reg + SW'(1);
                            if (cont_reg && !tail_any) state_next = kst_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            default: state_next = kst_pkg::ST_IDLE;
        endcase
    end

    // lookahead on later entries: whether a tick scan past sel_reg ends another
    // session with room left; also whether any remaining entry needs an update
    always_comb begin
        logic [4:0] c;
        tail_ends = 1'b0;
        tail_any  = 1'b0;
        c = cnt_reg + 5'd1;
        for (int i = 0; i < N; i++) begin
            if (SW'(i) > sel_reg && run_reg[i]) begin
                tail_any = 1'b1;
                if (left_reg[i] <= 16'd1 && active_reg[i] && !held_reg[i]
                    && c + 5'd2 <= 5'(kst_pkg::MAX_RESULTS)) begin
                    tail_ends = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= kst_pkg::ST_IDLE;
            active_reg     <= '0;
            held_reg       <= '0;
            first_reg      <= '0;
            run_reg        <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
            cont_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
            cont_reg       <= cont_next;
            if (w_en) begin
                active_reg[w_idx] <= w_act;
                held_reg[w_idx]   <= w_held;
                first_reg[w_idx]  <= w_first;
                run_reg[w_idx]    <= w_run;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg   <= sel_next;
        free_reg  <= free_next;
        ehold_reg <= ehold_next;
        if (w_en) begin
            key_reg[w_idx]  <= w_key;
            left_reg[w_idx] <= w_left;
        end
        if (s_valid && s_ready) begin
            req_reg   <= kst_pkg::req_t'(s_req_type);
            pos_reg   <= s_key_position;
            down_reg  <= s_key_down;
            layer_reg <= s_layer_index;
        end
    end

    // tick scan that emitted words must mark the last one; a scan that ends
    // after the last ending word has already marked it via lookahead
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == kst_pkg::ST_IDLE)) else $error("ready outside idle");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !out_full) else $error("push into full output register");
    a_one_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kst_pkg::ST_SCAN) |-> (idx_reg <= LAST_IDX))
        else $error("scan index out of range");
endmodule

@@ tb/kst_checker.sv @@
// checker: predicts session tracker actions and compares them with the result channel
module kst_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_key_position,
    input  logic        s_key_down,
    input  logic [4:0]  s_layer_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_action,
    input  logic [5:0]  m_action_position,
    input  logic [15:0] m_hold_ticks,
    input  logic        m_last_action,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending_actions
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] ign_keys;
    logic [31:0] ign_layers;
    logic [15:0] timeout;
    logic [15:0] tap_hold;

    logic        active  [kst_pkg::SESSIONS];
    logic        held    [kst_pkg::SESSIONS];
    logic        first   [kst_pkg::SESSIONS];
    logic [5:0]  key     [kst_pkg::SESSIONS];
    logic        running [kst_pkg::SESSIONS];
    logic [15:0] left    [kst_pkg::SESSIONS];

    kst_pkg::word_t expected_actions[$];
    int    n_words;

    assign pending_actions = expected_actions.size();

    function automatic void emit(kst_pkg::act_t a, logic [5:0] p, logic [15:0] h);
        kst_pkg::word_t w;
        if (n_words >= kst_pkg::MAX_RESULTS) return;
        w.action = a;
        w.position = p;
        w.hold = h;
        w.last = 1'b0;
        expected_actions.push_back(w);
        n_words++;
    endfunction

    function automatic void restart(int s);
        if (timeout != 0) begin
            running[s] = 1'b1;
            left[s] = timeout;
        end
    endfunction

    function automatic void end_session(int s, logic [15:0] h);
        if (held[s]) emit(kst_pkg::ACT_CONT_RELEASE, key[s], 16'd0);
        active[s] = 1'b0;
        running[s] = 1'b0;
        emit(kst_pkg::ACT_END_PRESS, key[s], h);
        emit(kst_pkg::ACT_END_RELEASE, key[s], 16'd0);
    endfunction

    function automatic int find_session(logic [5:0] p);
        for (int i = 0; i < kst_pkg::SESSIONS; i++)
            if (active[i] && key[i] == p) return i;
        return -1;
    endfunction

    function automatic void predict_actions(logic [2:0] req, logic [5:0] p, logic dn,
                                            logic [4:0] layer);
        int s;
        kst_pkg::word_t w;
        n_words = 0;
        case (req)
            kst_pkg::REQ_PRESS: begin
                s = find_session(p);
                if (s < 0) begin
                    for (int i = 0; i < kst_pkg::SESSIONS; i++)
                        if (!active[i]) begin
                            s = i;
                            break;
                        end
                    if (s >= 0) begin
                        active[s] = 1'b1;
                        key[s] = p;
                        first[s] = 1'b1;
                        running[s] = 1'b0;
                        left[s] = '0;
                    end
                end
                if (s >= 0) begin
                    held[s] = 1'b1;
                    if (first[s]) begin
                        emit(kst_pkg::ACT_START_PRESS, p, 16'd0);
                        emit(kst_pkg::ACT_START_RELEASE, p, 16'd0);
                        first[s] = 1'b0;
                    end
                    emit(kst_pkg::ACT_CONT_PRESS, p, 16'd0);
                end
            end
            kst_pkg::REQ_RELEASE: begin
                s = find_session(p);
                if (s >= 0) begin
                    held[s] = 1'b0;
                    emit(kst_pkg::ACT_CONT_RELEASE, p, 16'd0);
                    restart(s);
                end
            end
            kst_pkg::REQ_POS: begin
                for (int i = 0; i < kst_pkg::SESSIONS; i++) begin
                    if (!active[i] || key[i] == p) continue;
                    if (!ign_keys[p]) begin
                        end_session(i, tap_hold);
                        break;
                    end
                    if (dn) running[i] = 1'b0;
                    else restart(i);
                end
            end
            kst_pkg::REQ_LAYER: begin
                if (dn && !ign_layers[layer])
                    for (int i = 0; i < kst_pkg::SESSIONS; i++)
                        if (active[i]) begin
                            end_session(i, 16'd0);
                            break;
                        end
            end
            kst_pkg::REQ_TICK: begin
                for (int i = 0; i < kst_pkg::SESSIONS; i++) begin
                    if (!running[i]) continue;
                    if (left[i] != 0) left[i] = left[i] - 16'd1;
                    if (left[i] != 0) continue;
                    if (active[i] && !held[i]) begin
                        if (n_words + 2 > kst_pkg::MAX_RESULTS) continue;
                        end_session(i, tap_hold);
                    end else begin
                        running[i] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (n_words > 0) begin
            w = expected_actions.pop_back();
            w.last = 1'b1;
            expected_actions.push_back(w);
        end
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge aclk) begin
        kst_pkg::word_t e;
        if (!aresetn) begin
            ign_keys = '0;
            ign_layers = '0;
            timeout = '0;
            tap_hold = '0;
            for (int i = 0; i < kst_pkg::SESSIONS; i++) begin
                active[i] = 1'b0;
                held[i] = 1'b0;
                first[i] = 1'b0;
                key[i] = '0;
                running[i] = 1'b0;
                left[i] = '0;
            end
            expected_actions.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                case (kst_pkg::cfg_idx_t'(cfg_index))
                    kst_pkg::CFG_IGN_KEYS:   ign_keys = cfg_data;
                    kst_pkg::CFG_IGN_LAYERS: ign_layers = cfg_data[31:0];
                    kst_pkg::CFG_TIMEOUT:    timeout = cfg_data[15:0];
                    kst_pkg::CFG_TAP_HOLD:   tap_hold = cfg_data[15:0];
                    default: ;
                endcase
            if (m_valid && m_ready) begin
                if (expected_actions.size() == 0) begin
                    report($sformatf("unexpected word action %0d pos %0d",
                                     m_action, m_action_position));
                end else begin
                    e = expected_actions.pop_front();
                    if (m_action !== e.action)
                        report($sformatf("action %0d, want %0d", m_action, e.action));
                    if (m_action_position !== e.position)
                        report($sformatf("position %0d, want %0d",
                                         m_action_position, e.position));
                    if (m_hold_ticks !== e.hold)
                        report($sformatf("hold %0d, want %0d", m_hold_ticks, e.hold));
                    if (m_last_action !== e.last)
                        report($sformatf("last %0b, want %0b", m_last_action, e.last));
                end
            end
            if (s_valid && s_ready)
                predict_actions(s_req_type, s_key_position, s_key_down, s_layer_index);
        end
    end

    initial errors = 0;

endmodule

@@ tb/testbench.sv @@
// top of the session tracker testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_req_type;
    logic [5:0]  s_key_position;
    logic        s_key_down;
    logic [4:0]  s_layer_index;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_action;
    logic [5:0]  m_action_position;
    logic [15:0] m_hold_ticks;
    logic        m_last_action;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending_actions;
    int          idle_cycles;
    logic        stim_done;
    logic [5:0]  keyset[4];

    key_session_interrupt_tracker i_dut (.*);

    kst_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver: random stall per word
    initial begin
        int w;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (w != 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] req, logic [5:0] p, logic dn, logic [4:0] layer);
        int w;
        w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (w != 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_key_position <= p;
        s_key_down <= dn;
        s_layer_index <= layer;
        @(posedge aclk iff s_ready);
    endtask

    task automatic write_reg(kst_pkg::cfg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain then allow the block to finish a word-less item
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_actions != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_word(kst_pkg::REQ_PRESS, keyset[$urandom_range(0, 3)], 1'b0, 5'd0);
            else if (r < 55)
                send_word(kst_pkg::REQ_RELEASE, keyset[$urandom_range(0, 3)], 1'b0, 5'd0);
            else if (r < 65)
                send_word(kst_pkg::REQ_POS, 6'($urandom), 1'($urandom), 5'($urandom));
            else if (r < 72)
                send_word(kst_pkg::REQ_LAYER, 6'($urandom), 1'($urandom), 5'($urandom));
            else if (r < 97)
                send_word(kst_pkg::REQ_TICK, 6'($urandom), 1'($urandom), 5'($urandom));
            else
                send_word(3'($urandom_range(5, 7)), 6'($urandom), 1'($urandom),
                          5'($urandom));
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_req_type = '0;
        s_key_position = '0;
        s_key_down = 1'b0;
        s_layer_index = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stim_done = 1'b0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fill the table past full, ends via key, layer and expiry
        write_reg(kst_pkg::CFG_TIMEOUT, 64'd2);
        write_reg(kst_pkg::CFG_TAP_HOLD, 64'hffff);
        write_reg(kst_pkg::CFG_IGN_KEYS, 64'h8000_0000_0000_0001);
        write_reg(kst_pkg::CFG_IGN_LAYERS, 64'h8000_0001);
        for (int k = 0; k < 11; k++) send_word(kst_pkg::REQ_PRESS, 6'(k * 6), 1'b0, 5'd0);
        send_word(kst_pkg::REQ_PRESS, 6'd0, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_RELEASE, 6'd0, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_RELEASE, 6'd1, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_POS, 6'd63, 1'b1, 5'd0);
        send_word(kst_pkg::REQ_POS, 6'd63, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_TICK, 6'd0, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_TICK, 6'd0, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_POS, 6'd5, 1'b1, 5'd0);
        send_word(kst_pkg::REQ_LAYER, 6'd0, 1'b1, 5'd31);
        send_word(kst_pkg::REQ_LAYER, 6'd0, 1'b0, 5'd4);
        send_word(kst_pkg::REQ_LAYER, 6'd0, 1'b1, 5'd4);
        send_word(3'd7, 6'd0, 1'b0, 5'd0);
        for (int k = 0; k < 10; k++)
            send_word(kst_pkg::REQ_RELEASE, 6'(k * 6), 1'b0, 5'd0);
        send_word(kst_pkg::REQ_TICK, 6'd0, 1'b0, 5'd0);
        send_word(kst_pkg::REQ_TICK, 6'd0, 1'b0, 5'd0);
        settle();

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 4; k++) keyset[k] = 6'($urandom);
            write_reg(kst_pkg::CFG_IGN_KEYS, ph == 0 ? 64'hffff_ffff_ffff_ffff :
                      ph == 1 ? 64'd0 : {$urandom, $urandom});
            write_reg(kst_pkg::CFG_IGN_LAYERS, ph == 0 ? 64'hffff_ffff : ph == 1 ? 64'd0 :
                      64'($urandom));
            write_reg(kst_pkg::CFG_TIMEOUT, ph == 1 ? 64'd0 : ph == 4 ? 64'hffff :
                      64'($urandom_range(1, 4)));
            write_reg(kst_pkg::CFG_TAP_HOLD, ph == 1 ? 64'd0 : 64'($urandom_range(0, 65535)));
            random_phase(25);
            settle();
        end

        stim_done <= 1'b1;
    end

    initial begin
        @(posedge aclk iff stim_done);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
